@@ hw/rtl/sat_pkg.sv @@
// shared constants, types and state codes of the score accumulate table
package sat_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int DOC_W   = 24;
   localparam int HITS_W  = 16;
   localparam int SCORE_W = 32;
   localparam int RSLOT_W = 10;
   localparam int STAT_W  = 3;
   localparam int OSLOT_W = 10;
   localparam int OCNT_W  = 11;

   // 999999.0 in Q24.8
   localparam logic [SCORE_W-1:0] LOW_MARK_RESET = 32'd255999744;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_MERGED    = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_APPENDED  = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_READ_OK   = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_READ_OOR  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_PLACE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [DOC_W-1:0]   doc;
      logic [HITS_W-1:0]  hits;
      logic [SCORE_W-1:0] score;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               req_type;
      logic [DOC_W-1:0]   doc_index;
      logic [HITS_W-1:0]  hit_count;
      logic [SCORE_W-1:0] score;
      logic [RSLOT_W-1:0] read_slot;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [OSLOT_W-1:0] slot;
      logic [DOC_W-1:0]   doc_out;
      logic [HITS_W-1:0]  hits_total;
      logic [SCORE_W-1:0] score_total;
      logic [OCNT_W-1:0]  entry_count;
      logic [SCORE_W-1:0] min_score;
      logic [SCORE_W-1:0] max_score;
   } rsp_item_type;

endpackage

@@ hw/rtl/sat_req_if.sv @@
// request channel of the score accumulate table
interface sat_req_if;
   import sat_pkg::*;

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [DOC_W-1:0]   doc_index;
   logic [HITS_W-1:0]  hit_count;
   logic [SCORE_W-1:0] score;
   logic [RSLOT_W-1:0] read_slot;

   modport source (output valid, req_type, doc_index, hit_count, score, read_slot,
                   input ready);
   modport sink   (input valid, req_type, doc_index, hit_count, score, read_slot,
                   output ready);
endinterface

@@ hw/rtl/sat_rsp_if.sv @@
// response channel of the score accumulate table
interface sat_rsp_if;
   import sat_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [OSLOT_W-1:0] slot;
   logic [DOC_W-1:0]   doc_out;
   logic [HITS_W-1:0]  hits_total;
   logic [SCORE_W-1:0] score_total;
   logic [OCNT_W-1:0]  entry_count;
   logic [SCORE_W-1:0] min_score;
   logic [SCORE_W-1:0] max_score;

   modport source (output valid, status, slot, doc_out, hits_total, score_total,
                   entry_count, min_score, max_score, input ready);
   modport sink   (input valid, status, slot, doc_out, hits_total, score_total,
                   entry_count, min_score, max_score, output ready);
endinterface

@@ hw/rtl/sat_ram.sv @@
// generic single write, single read ram with registered read data
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/score_accumulate_table_top.sv @@
// top level of the score accumulate table: sequencer, table ram and response register
//
// usage
//   req_ch carries one request: an add of a hit record (doc_index, hit_count, score)
//   or a read of the entry at read_slot. rsp_ch returns exactly one response per
//   request, in request order. csr_wr_en / csr_wr_data write add_hit_counts; write
//   it only while no request is in flight.
// sequencing
//   the block takes one request at a time; req_ch.ready is low while it works.
//   read in range: one ram read, answered from ST_READ. read out of range: answered
//   as the request is accepted. add: ST_SCAN compares the live entries in order
//   until a match or the last live entry, then ST_MERGE or ST_PLACE; the linear
//   scan through the single ram read port, one entry per cycle, sets the length
//   of an add. an add on an empty table goes straight from idle to ST_PLACE.
// reset
//   synchronous, active high. the table becomes empty (fill count zero), the
//   running minimum returns to 999999.0 and the maximum to 0. ram contents are not
//   cleared; only slots below the fill count are ever read, so no clearing pass.
// stalls
//   a finished response sits in the response register until taken; a new request
//   is accepted in the same cycle the old response leaves.
module score_accumulate_table_top (
   input  logic      clock,
   input  logic      reset,
   sat_req_if.sink   req_ch,
   sat_rsp_if.source rsp_ch,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import sat_pkg::*;

   // sequencer and control state
   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  used_count_ff, used_count_in;
   logic [SCORE_W-1:0]  low_mark_ff, low_mark_in;
   logic [SCORE_W-1:0]  high_mark_ff, high_mark_in;
   logic                add_hits_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_item_type        req_ff, req_in;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   entry_type           hold_ff, hold_in;
   rsp_item_type        rsp_ff, rsp_in;

   // table ram port
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr;
   entry_type           ram_wdata;
   logic [SLOT_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata_raw;
   entry_type           ram_rdata;

   logic                req_accept;
   logic                rsp_load;
   req_item_type        req_item;
   logic [HITS_W:0]     hit_sum;
   logic [SCORE_W:0]    score_sum;
   logic [HITS_W-1:0]   hit_merged;
   logic [SCORE_W-1:0]  score_merged;
   logic                scan_last;
   logic                read_in_range;

   sat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   // incoming request gathered into one word
   assign req_item.req_type  = req_ch.req_type;
   assign req_item.doc_index = req_ch.doc_index;
   assign req_item.hit_count = req_ch.hit_count;
   assign req_item.score     = req_ch.score;
   assign req_item.read_slot = req_ch.read_slot;

   // only idle with a free or departing response register can take a request
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // the adder pair of the merge step, saturating; hits only add while add_hits_ff is set
   assign hit_sum      = {1'b0, hold_ff.hits} + {1'b0, req_ff.hit_count};
   assign score_sum    = {1'b0, hold_ff.score} + {1'b0, req_ff.score};
   assign hit_merged   = !add_hits_ff ? hold_ff.hits :
                         (hit_sum[HITS_W] ? {HITS_W{1'b1}} : hit_sum[HITS_W-1:0]);
   assign score_merged = score_sum[SCORE_W] ? {SCORE_W{1'b1}} : score_sum[SCORE_W-1:0];

   // the scan has reached the last live entry
   assign scan_last = ({1'b0, scan_idx_ff} + 1'b1) == used_count_ff;

   assign read_in_range = COUNT_W'(req_ch.read_slot) < used_count_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_idx_in   = scan_idx_ff;
      hold_in       = hold_ff;
      used_count_in = used_count_ff;
      low_mark_in   = low_mark_ff;
      high_mark_in  = high_mark_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      rsp_load      = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = scan_idx_ff;
      ram_wdata     = hold_ff;
      ram_raddr     = scan_idx_ff + 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_item;
               if (req_item.req_type == REQ_READ) begin
                  if (read_in_range) begin
                     ram_raddr   = SLOT_W'(req_item.read_slot);
                     scan_idx_in = SLOT_W'(req_item.read_slot);
                     state_in    = ST_READ;
                  end else begin
                     rsp_load           = 1'b1;
                     rsp_in.status      = STATUS_READ_OOR;
                     rsp_in.slot        = OSLOT_W'(req_item.read_slot);
                     rsp_in.doc_out     = '0;
                     rsp_in.hits_total  = '0;
                     rsp_in.score_total = '0;
                  end
               end else if (used_count_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_raddr   = '0;
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // ram data belongs to scan_idx_ff, next address already issued
            if (ram_rdata.doc == req_ff.doc_index) begin
               hold_in  = ram_rdata;
               state_in = ST_MERGE;
            end else if (scan_last) begin
               state_in = ST_PLACE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         ST_MERGE: begin
            ram_we          = 1'b1;
            ram_waddr       = scan_idx_ff;
            ram_wdata.doc   = hold_ff.doc;
            ram_wdata.hits  = hit_merged;
            ram_wdata.score = score_merged;
            // marks follow the incoming score, not the sum
            if (req_ff.score > high_mark_ff) begin
               high_mark_in = req_ff.score;
            end
            if (req_ff.score < low_mark_ff) begin
               low_mark_in = req_ff.score;
            end
            rsp_load           = 1'b1;
            rsp_in.status      = STATUS_MERGED;
            rsp_in.slot        = OSLOT_W'(scan_idx_ff);
            rsp_in.doc_out     = hold_ff.doc;
            rsp_in.hits_total  = hit_merged;
            rsp_in.score_total = score_merged;
            state_in           = ST_IDLE;
         end

         ST_PLACE: begin
            rsp_load = 1'b1;
            if (used_count_ff < COUNT_W'(TABLE_DEPTH)) begin
               ram_we             = 1'b1;
               ram_waddr          = used_count_ff[SLOT_W-1:0];
               ram_wdata.doc      = req_ff.doc_index;
               ram_wdata.hits     = req_ff.hit_count;
               ram_wdata.score    = req_ff.score;
               used_count_in      = used_count_ff + 1'b1;
               rsp_in.status      = STATUS_APPENDED;
               rsp_in.slot        = OSLOT_W'(used_count_ff[SLOT_W-1:0]);
               rsp_in.doc_out     = req_ff.doc_index;
               rsp_in.hits_total  = req_ff.hit_count;
               rsp_in.score_total = req_ff.score;
            end else begin
               // table full, record dropped
               rsp_in.status      = STATUS_FULL;
               rsp_in.slot        = '0;
               rsp_in.doc_out     = req_ff.doc_index;
               rsp_in.hits_total  = '0;
               rsp_in.score_total = '0;
            end
            state_in = ST_IDLE;
         end

         ST_READ: begin
            rsp_load           = 1'b1;
            rsp_in.status      = STATUS_READ_OK;
            rsp_in.slot        = OSLOT_W'(scan_idx_ff);
            rsp_in.doc_out     = ram_rdata.doc;
            rsp_in.hits_total  = ram_rdata.hits;
            rsp_in.score_total = ram_rdata.score;
            state_in           = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // table-wide fields reflect the state after this request
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.entry_count = OCNT_W'(used_count_in);
         rsp_in.min_score   = low_mark_in;
         rsp_in.max_score   = high_mark_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_count_ff <= '0;
         low_mark_ff   <= LOW_MARK_RESET;
         high_mark_ff  <= '0;
         add_hits_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         low_mark_ff   <= low_mark_in;
         high_mark_ff  <= high_mark_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            add_hits_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.slot        = rsp_ff.slot;
   assign rsp_ch.doc_out     = rsp_ff.doc_out;
   assign rsp_ch.hits_total  = rsp_ff.hits_total;
   assign rsp_ch.score_total = rsp_ff.score_total;
   assign rsp_ch.entry_count = rsp_ff.entry_count;
   assign rsp_ch.min_score   = rsp_ff.min_score;
   assign rsp_ch.max_score   = rsp_ff.max_score;

   // response register is empty whenever the sequencer is busy
   a_busy_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while sequencer busy");

   // fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // a merge points at a live slot and leaves min not above max
   a_merge_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_MERGED) |->
         (COUNT_W'(rsp_ff.slot) < used_count_ff && rsp_ff.min_score <= rsp_ff.max_score))
      else $error("merge response inconsistent");

   // table ram is written only by the merge and place steps
   a_write_steps: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_MERGE || state_ff == ST_PLACE))
      else $error("table write outside merge or place");

   // an append grows the fill count by exactly one
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE && ram_we) |=> (used_count_ff == $past(used_count_ff) + 1'b1))
      else $error("append did not grow fill count");

endmodule

@@ test/score_accumulate_table_top_tb.sv @@
// self-checking bench for the score accumulate table, every response against a predicted one
`timescale 1ns / 100ps

module score_accumulate_table_top_tb;
   import sat_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   // an add scans at most TABLE_DEPTH entries, the long receiver hold-off is set by HOLD_OFF_CYCLES
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int DOC_POOL_N = 48;
   localparam int PHASE_ITEMS = 145;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sat_req_if req_bus ();
   sat_rsp_if rsp_bus ();

   score_accumulate_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // bench copy of the hit table, its marks and the hit-count mode
   entry_type          tbl_entry [TABLE_DEPTH];
   int                 tbl_used;
   logic [SCORE_W-1:0] tbl_low;
   logic [SCORE_W-1:0] tbl_high;
   logic               tbl_add_hits;

   // predicted responses, oldest first
   rsp_item_type       awaited_rsp_q [$];

   logic [DOC_W-1:0]   doc_pool [DOC_POOL_N];
   int                 fail_count = 0;
   int                 req_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 rsp_hold_left = 0;
   int                 quiet_cycles = 0;

   // ---------------------------------------------------------------- prediction

   function automatic bit table_holds(input logic [DOC_W-1:0] doc);
      int i;
      for (i = 0; i < tbl_used; i++)
         if (tbl_entry[i].doc == doc) return 1'b1;
      return 1'b0;
   endfunction

   // applies one request to the bench table and returns the response it must produce
   function automatic rsp_item_type table_predict(input req_item_type r);
      rsp_item_type     rsp;
      logic [HITS_W:0]  hit_sum;
      logic [SCORE_W:0] score_sum;
      int               found;
      int               i;
      rsp = '0;
      found = -1;
      if (r.req_type == REQ_READ) begin
         rsp.slot = r.read_slot;
         if (int'(r.read_slot) < tbl_used) begin
            rsp.status      = STATUS_READ_OK;
            rsp.doc_out     = tbl_entry[r.read_slot].doc;
            rsp.hits_total  = tbl_entry[r.read_slot].hits;
            rsp.score_total = tbl_entry[r.read_slot].score;
         end else begin
            // out of range: data fields stay zero
            rsp.status = STATUS_READ_OOR;
         end
      end else begin
         // lowest matching slot wins
         for (i = 0; i < tbl_used; i++) begin
            if (tbl_entry[i].doc == r.doc_index) begin
               found = i;
               break;
            end
         end
         if (found >= 0) begin
            if (tbl_add_hits) begin
               hit_sum = {1'b0, tbl_entry[found].hits} + {1'b0, r.hit_count};
               tbl_entry[found].hits = hit_sum[HITS_W] ? '1 : hit_sum[HITS_W-1:0];
            end
            score_sum = {1'b0, tbl_entry[found].score} + {1'b0, r.score};
            tbl_entry[found].score = score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
            // marks follow the incoming score, not the sum
            if (r.score > tbl_high) tbl_high = r.score;
            if (r.score < tbl_low) tbl_low = r.score;
            rsp.status      = STATUS_MERGED;
            rsp.slot        = OSLOT_W'(found);
            rsp.doc_out     = tbl_entry[found].doc;
            rsp.hits_total  = tbl_entry[found].hits;
            rsp.score_total = tbl_entry[found].score;
         end else if (tbl_used < TABLE_DEPTH) begin
            // new entry keeps the incoming hit count whatever the mode
            tbl_entry[tbl_used] = '{doc: r.doc_index, hits: r.hit_count, score: r.score};
            rsp.status      = STATUS_APPENDED;
            rsp.slot        = OSLOT_W'(tbl_used);
            rsp.doc_out     = r.doc_index;
            rsp.hits_total  = r.hit_count;
            rsp.score_total = r.score;
            tbl_used++;
         end else begin
            rsp.status  = STATUS_FULL;
            rsp.doc_out = r.doc_index;
         end
      end
      rsp.entry_count = OCNT_W'(tbl_used);
      rsp.min_score   = tbl_low;
      rsp.max_score   = tbl_high;
      return rsp;
   endfunction

   // ---------------------------------------------------------------- request building

   function automatic req_item_type make_add(input logic [DOC_W-1:0] doc,
                                             input logic [HITS_W-1:0] hits,
                                             input logic [SCORE_W-1:0] score);
      req_item_type r;
      r.req_type  = REQ_ADD;
      r.doc_index = doc;
      r.hit_count = hits;
      r.score     = score;
      r.read_slot = RSLOT_W'($urandom());
      return r;
   endfunction

   function automatic req_item_type make_read(input logic [RSLOT_W-1:0] slot_nr);
      req_item_type r;
      r.req_type  = REQ_READ;
      r.doc_index = DOC_W'($urandom());
      r.hit_count = HITS_W'($urandom());
      r.score     = $urandom();
      r.read_slot = slot_nr;
      return r;
   endfunction

   function automatic logic [HITS_W-1:0] random_hits();
      case ($urandom_range(2))
         0:       return HITS_W'($urandom_range(15));
         1:       return HITS_W'($urandom());
         default: return {8'hFF, 8'($urandom())};
      endcase
   endfunction

   // small, full range, near saturation, or right around the reset low mark
   function automatic logic [SCORE_W-1:0] random_score();
      case ($urandom_range(3))
         0:       return SCORE_W'($urandom_range(1023));
         1:       return $urandom();
         2:       return {16'hFFFF, 16'($urandom())};
         default: return LOW_MARK_RESET + SCORE_W'($urandom_range(64)) - 32'd32;
      endcase
   endfunction

   function automatic logic [DOC_W-1:0] fresh_doc();
      logic [DOC_W-1:0] d;
      do d = DOC_W'($urandom()); while (table_holds(d));
      return d;
   endfunction

   // mostly adds on a small document pool so merges dominate, some new documents and reads
   function automatic req_item_type random_request();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         if (tbl_used > 0 && $urandom_range(3) != 0)
            return make_read(RSLOT_W'($urandom_range(tbl_used - 1)));
         return make_read(RSLOT_W'($urandom()));
      end
      if (pick < 21)
         return make_add(DOC_W'($urandom()), random_hits(), random_score());
      return make_add(doc_pool[$urandom_range(DOC_POOL_N - 1)], random_hits(), random_score());
   endfunction

   // ---------------------------------------------------------------- driving

   // offers one request and returns at the edge where it is taken; valid is left high
   // so a following call can present the next request without a bubble
   task automatic send_request(input req_item_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.req_type  <= 1'($urandom());
         req_bus.doc_index <= DOC_W'($urandom());
         req_bus.hit_count <= HITS_W'($urandom());
         req_bus.score     <= $urandom();
         req_bus.read_slot <= RSLOT_W'($urandom());
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= r.req_type;
      req_bus.doc_index <= r.doc_index;
      req_bus.hit_count <= r.hit_count;
      req_bus.score     <= r.score;
      req_bus.read_slot <= r.read_slot;
      do @(posedge clock); while (!req_bus.ready);
      awaited_rsp_q.push_back(table_predict(r));
   endtask

   // drops valid in the same step as the last acceptance, then waits for every response
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   // only called with the block drained
   task automatic write_hit_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      tbl_add_hits = mode;
      csr_wr_en   <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_response(input rsp_item_type got);
      rsp_item_type want;
      if (awaited_rsp_q.size() == 0) begin
         $error("response with no request outstanding: status %0d slot %0d",
                got.status, got.slot);
         fail_count++;
         return;
      end
      want = awaited_rsp_q.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("slot", 32'(want.slot), 32'(got.slot));
      check_field("doc_out", 32'(want.doc_out), 32'(got.doc_out));
      check_field("hits_total", 32'(want.hits_total), 32'(got.hits_total));
      check_field("score_total", want.score_total, got.score_total);
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("min_score", want.min_score, got.min_score);
      check_field("max_score", want.max_score, got.max_score);
   endtask

   // response side: take what was accepted at this edge, then pick ready for the next cycle
   initial begin : rsp_sink
      rsp_item_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status      = rsp_bus.status;
            got.slot        = rsp_bus.slot;
            got.doc_out     = rsp_bus.doc_out;
            got.hits_total  = rsp_bus.hits_total;
            got.score_total = rsp_bus.score_total;
            got.entry_count = rsp_bus.entry_count;
            got.min_score   = rsp_bus.min_score;
            got.max_score   = rsp_bus.max_score;
            check_response(got);
         end
         if (rsp_hold_left > 0) begin
            // long hold-off so the response register stays full and the input stalls
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog: ends the run if neither channel moves anything for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // extremes of every field, both modes, saturation, mark updates, reads in and out of range
   task automatic test_directed_edges();
      // empty table: every read is out of range
      send_request(make_read('0));
      send_request(make_read('1));
      send_request(make_add('0, '0, '0));
      send_request(make_add('1, '1, '1));
      // mode off: hit count is not added, score saturates, high mark jumps to max
      send_request(make_add('0, '1, '1));
      send_request(make_add('1, 16'd1, 32'd1));
      // just below and exactly at the reset low mark
      send_request(make_add(24'h123456, 16'd10, LOW_MARK_RESET - 32'd1));
      send_request(make_add(24'h123456, 16'd3, LOW_MARK_RESET));
      send_request(make_read(10'd0));
      send_request(make_read(10'd1));
      send_request(make_read(10'd2));
      // slot equal to the fill count is out of range
      send_request(make_read(10'd3));
      send_request(make_read(10'd1023));
      drain_responses();
      write_hit_mode(1'b1);
      // mode on: hit sums, exact top value and saturation
      send_request(make_add('1, 16'd1, 32'd5));
      send_request(make_add(24'h123456, 16'hFFF0, '0));
      send_request(make_add(24'h123456, 16'd5, 32'd7));
      send_request(make_add(24'h123456, 16'd6, 32'd7));
      // append keeps the incoming hit count regardless of mode
      send_request(make_add(24'hABCDEF, 16'd0, 32'h8000_0000));
      send_request(make_read(10'd2));
      send_request(make_read(10'd3));
      drain_responses();
      write_hit_mode(1'b0);
      send_request(make_add(24'hABCDEF, 16'd7, 32'h8000_0000));
      send_request(make_read(10'd3));
      drain_responses();
   endtask

   // random traffic in four idling phases, hit-count mode toggled between phases
   task automatic test_random_traffic();
      int phase_req_pct [4] = '{0, 79, 0, 9};
      int phase_rsp_pct [4] = '{0, 0, 79, 9};
      int p;
      int n;
      doc_pool[0] = '0;
      doc_pool[1] = '1;
      for (n = 2; n < DOC_POOL_N; n++) doc_pool[n] = DOC_W'($urandom());
      for (p = 0; p < 4; p++) begin
         write_hit_mode(p[0]);
         req_idle_pct  = phase_req_pct[p];
         rsp_stall_pct = phase_rsp_pct[p];
         for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
         drain_responses();
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering requests
   task automatic test_response_backpressure();
      int n;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = HOLD_OFF_CYCLES;
      for (n = 0; n < 20; n++) send_request(random_request());
      drain_responses();
   endtask

   // fill every slot, then drops, merges at both ends, reads at both ends and the middle, and random traffic
   task automatic test_table_full();
      int n;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_hit_mode(1'b1);
      while (tbl_used < TABLE_DEPTH)
         send_request(make_add(fresh_doc(), random_hits(), random_score()));
      for (n = 0; n < 4; n++)
         send_request(make_add(fresh_doc(), random_hits(), random_score()));
      send_request(make_add(tbl_entry[TABLE_DEPTH-1].doc, random_hits(), random_score()));
      send_request(make_add(tbl_entry[0].doc, random_hits(), random_score()));
      send_request(make_read('1));
      send_request(make_read('0));
      send_request(make_read(10'd512));
      drain_responses();
      write_hit_mode(1'b0);
      req_idle_pct  = 9;
      rsp_stall_pct = 9;
      for (n = 0; n < 20; n++) send_request(random_request());
      drain_responses();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main_sequence
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_ADD;
      req_bus.doc_index <= '0;
      req_bus.hit_count <= '0;
      req_bus.score     <= '0;
      req_bus.read_slot <= '0;
      tbl_used     = 0;
      tbl_low      = LOW_MARK_RESET;
      tbl_high     = '0;
      tbl_add_hits = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_random_traffic();
      test_response_backpressure();
      test_table_full();

      drain_responses();
      // an add on a full table is the longest job; let any stray response show up
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (awaited_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", awaited_rsp_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/sat_pkg.sv
hw/rtl/sat_req_if.sv
hw/rtl/sat_rsp_if.sv
hw/rtl/sat_ram.sv
hw/rtl/score_accumulate_table_top.sv
test/score_accumulate_table_top_tb.sv
